>>> rtl/core/rfalu_pkg.sv
// Package for the rational fraction ALU: widths, opcodes, controller states
// and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rfalu_pkg;

   localparam int unsigned OPERAND_WIDTH = 16;
   localparam int unsigned PROD_WIDTH    = 2 * OPERAND_WIDTH;
   localparam int unsigned RES_WIDTH     = PROD_WIDTH + 1;
   localparam int unsigned OPCODE_WIDTH  = 3;
   localparam int unsigned CNT_WIDTH     = $clog2(RES_WIDTH + 1);

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_ADD    = 3'd0,
      OP_SUB    = 3'd1,
      OP_MUL    = 3'd2,
      OP_DIV    = 3'd3,
      OP_REDUCE = 3'd4
   } opcode_type;

   typedef enum logic [2:0] {
      MUL_NA_DB,
      MUL_NB_DA,
      MUL_DA_DB,
      MUL_NA_NB,
      MUL_DA_NB
   } mul_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_NUM_SET,
      ACC_NUM_ADD,
      ACC_NUM_SUB,
      ACC_DEN_SET
   } acc_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_MUL4,
      ST_GCD_INIT,
      ST_GCD,
      ST_DIV_INIT,
      ST_DIV,
      ST_SIGN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      acc_type     acc;
      logic        gcd_init;
      logic        gcd_step;
      logic        div_init;
      logic        div_step;
      logic        sign_fix;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic [OPCODE_WIDTH-1:0] opcode;
      logic                    zero_part;
      logic                    gcd_done;
      logic                    div_done;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/core/rfalu_ctrl.sv
// Controller state machine for the rational fraction ALU.
// Depends on rfalu_pkg; drives the datapath through rfalu_pkg::cmd_type.
`timescale 1ns / 1ps
`default_nettype none

module rfalu_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                rsp_stall,
   output logic                     rsp_valid,
   output rfalu_pkg::cmd_type       cmd,
   input  wire rfalu_pkg::status_type status
);

   rfalu_pkg::state_type state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 addsub;

   assign addsub    = (status.opcode == rfalu_pkg::OP_ADD) ||
                      (status.opcode == rfalu_pkg::OP_SUB);
   assign req_stall = (state_ff != rfalu_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rfalu_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.mul_sel  = rfalu_pkg::MUL_NA_DB;
      cmd.acc      = rfalu_pkg::ACC_HOLD;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         rfalu_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = rfalu_pkg::ST_DECODE;
            end
         end
         rfalu_pkg::ST_DECODE: begin
            if (status.opcode inside {rfalu_pkg::OP_ADD, rfalu_pkg::OP_SUB,
                                      rfalu_pkg::OP_MUL, rfalu_pkg::OP_DIV}) begin
               state_in = rfalu_pkg::ST_MUL1;
            end else if (status.opcode == rfalu_pkg::OP_REDUCE) begin
               state_in = rfalu_pkg::ST_GCD_INIT;
            end else begin
               state_in = rfalu_pkg::ST_DONE;
            end
         end
         rfalu_pkg::ST_MUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = (status.opcode == rfalu_pkg::OP_MUL) ?
                          rfalu_pkg::MUL_NA_NB : rfalu_pkg::MUL_NA_DB;
            state_in    = rfalu_pkg::ST_MUL2;
         end
         rfalu_pkg::ST_MUL2: begin
            cmd.mul_en = 1'b1;
            cmd.acc    = rfalu_pkg::ACC_NUM_SET;
            if (status.opcode == rfalu_pkg::OP_MUL) begin
               cmd.mul_sel = rfalu_pkg::MUL_DA_DB;
            end else if (status.opcode == rfalu_pkg::OP_DIV) begin
               cmd.mul_sel = rfalu_pkg::MUL_DA_NB;
            end else begin
               cmd.mul_sel = rfalu_pkg::MUL_NB_DA;
            end
            state_in = rfalu_pkg::ST_MUL3;
         end
         rfalu_pkg::ST_MUL3: begin
            if (addsub) begin
               cmd.mul_en  = 1'b1;
               cmd.mul_sel = rfalu_pkg::MUL_DA_DB;
               cmd.acc     = (status.opcode == rfalu_pkg::OP_SUB) ?
                             rfalu_pkg::ACC_NUM_SUB : rfalu_pkg::ACC_NUM_ADD;
               state_in    = rfalu_pkg::ST_MUL4;
            end else begin
               cmd.acc  = rfalu_pkg::ACC_DEN_SET;
               state_in = (status.opcode == rfalu_pkg::OP_DIV) ?
                          rfalu_pkg::ST_GCD_INIT : rfalu_pkg::ST_DONE;
            end
         end
         rfalu_pkg::ST_MUL4: begin
            cmd.acc  = rfalu_pkg::ACC_DEN_SET;
            state_in = rfalu_pkg::ST_DONE;
         end
         rfalu_pkg::ST_GCD_INIT: begin
            if (status.zero_part) begin
               state_in = rfalu_pkg::ST_DONE;
            end else begin
               cmd.gcd_init = 1'b1;
               state_in     = rfalu_pkg::ST_GCD;
            end
         end
         rfalu_pkg::ST_GCD: begin
            if (status.gcd_done) begin
               state_in = rfalu_pkg::ST_DIV_INIT;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         rfalu_pkg::ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = rfalu_pkg::ST_DIV;
         end
         rfalu_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = rfalu_pkg::ST_SIGN;
            end
         end
         rfalu_pkg::ST_SIGN: begin
            cmd.sign_fix = 1'b1;
            state_in     = rfalu_pkg::ST_DONE;
         end
         rfalu_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = rfalu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rfalu_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/rfalu_datapath.sv
// Datapath for the rational fraction ALU: shared multiplier, accumulator,
// binary GCD unit, dual restoring divider and output register. Uses rfalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfalu_datapath (
   input  wire logic                                  clock,
   input  wire rfalu_pkg::cmd_type                    cmd,
   output rfalu_pkg::status_type                      status,
   input  wire logic [rfalu_pkg::OPCODE_WIDTH-1:0]    req_opcode,
   input  wire logic signed [rfalu_pkg::OPERAND_WIDTH-1:0] req_num_a,
   input  wire logic signed [rfalu_pkg::OPERAND_WIDTH-1:0] req_den_a,
   input  wire logic signed [rfalu_pkg::OPERAND_WIDTH-1:0] req_num_b,
   input  wire logic signed [rfalu_pkg::OPERAND_WIDTH-1:0] req_den_b,
   output logic signed [rfalu_pkg::RES_WIDTH-1:0]     rsp_res_num,
   output logic signed [rfalu_pkg::RES_WIDTH-1:0]     rsp_res_den,
   output logic                                       rsp_zero_den
);

   localparam int unsigned OW = rfalu_pkg::OPERAND_WIDTH;
   localparam int unsigned PW = rfalu_pkg::PROD_WIDTH;
   localparam int unsigned RW = rfalu_pkg::RES_WIDTH;
   localparam int unsigned CW = rfalu_pkg::CNT_WIDTH;

   logic [rfalu_pkg::OPCODE_WIDTH-1:0] op_ff;
   logic signed [OW-1:0] na_ff, da_ff, nb_ff, db_ff;
   logic signed [OW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [RW-1:0] prod_ext;
   logic signed [RW-1:0] num_ff, num_in, den_ff, den_in;
   logic [RW-1:0] num_mag, den_mag;
   logic [RW-1:0] gcd_a_ff, gcd_a_in, gcd_b_ff, gcd_b_in;
   logic [CW-1:0] shift_ff, shift_in;
   logic [RW-1:0] divisor_ff;
   logic [RW-1:0] quo_n_ff, quo_n_in, quo_d_ff, quo_d_in;
   logic [RW-1:0] rem_n_ff, rem_n_in, rem_d_ff, rem_d_in;
   logic [RW:0]   rem_n_sh, rem_d_sh, rem_n_sub, rem_d_sub;
   logic          ge_n, ge_d;
   logic [CW-1:0] div_cnt_ff;
   logic signed [RW-1:0] res_num_ff, res_den_ff;
   logic          zero_den_ff;

   // operand select for the shared multiplier
   always_comb begin
      case (cmd.mul_sel)
         rfalu_pkg::MUL_NA_DB: begin mul_a = na_ff; mul_b = db_ff; end
         rfalu_pkg::MUL_NB_DA: begin mul_a = nb_ff; mul_b = da_ff; end
         rfalu_pkg::MUL_DA_DB: begin mul_a = da_ff; mul_b = db_ff; end
         rfalu_pkg::MUL_NA_NB: begin mul_a = na_ff; mul_b = nb_ff; end
         rfalu_pkg::MUL_DA_NB: begin mul_a = da_ff; mul_b = nb_ff; end
         default:              begin mul_a = na_ff; mul_b = db_ff; end
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign prod_ext = {prod_ff[PW-1], prod_ff};

   assign num_mag = num_ff[RW-1] ? (RW'(0) - RW'(num_ff)) : RW'(num_ff);
   assign den_mag = den_ff[RW-1] ? (RW'(0) - RW'(den_ff)) : RW'(den_ff);

   // numerator / denominator update
   always_comb begin
      num_in = num_ff;
      den_in = den_ff;
      if (cmd.load) begin
         num_in = {{(RW-OW){req_num_a[OW-1]}}, req_num_a};
         den_in = {{(RW-OW){req_den_a[OW-1]}}, req_den_a};
      end else if (cmd.sign_fix) begin
         num_in = num_ff[RW-1] ? (RW'(0) - quo_n_ff) : quo_n_ff;
         den_in = den_ff[RW-1] ? (RW'(0) - quo_d_ff) : quo_d_ff;
      end else begin
         case (cmd.acc)
            rfalu_pkg::ACC_NUM_SET: num_in = prod_ext;
            rfalu_pkg::ACC_NUM_ADD: num_in = num_ff + prod_ext;
            rfalu_pkg::ACC_NUM_SUB: num_in = num_ff - prod_ext;
            rfalu_pkg::ACC_DEN_SET: den_in = prod_ext;
            default: ;
         endcase
      end
   end

   // binary GCD: strip shared twos, halve the even one, subtract when both odd
   always_comb begin
      gcd_a_in = gcd_a_ff;
      gcd_b_in = gcd_b_ff;
      shift_in = shift_ff;
      if (cmd.gcd_init) begin
         gcd_a_in = num_mag;
         gcd_b_in = den_mag;
         shift_in = '0;
      end else if (cmd.gcd_step) begin
         if (!gcd_a_ff[0] && !gcd_b_ff[0]) begin
            gcd_a_in = gcd_a_ff >> 1;
            gcd_b_in = gcd_b_ff >> 1;
            shift_in = shift_ff + 1'b1;
         end else if (!gcd_a_ff[0]) begin
            gcd_a_in = gcd_a_ff >> 1;
         end else if (!gcd_b_ff[0]) begin
            gcd_b_in = gcd_b_ff >> 1;
         end else if (gcd_a_ff > gcd_b_ff) begin
            gcd_a_in = gcd_a_ff - gcd_b_ff;
         end else begin
            gcd_b_in = gcd_b_ff - gcd_a_ff;
         end
      end
   end

   // restoring division of both magnitudes by the GCD, one bit per cycle
   assign rem_n_sh  = {rem_n_ff, quo_n_ff[RW-1]};
   assign rem_d_sh  = {rem_d_ff, quo_d_ff[RW-1]};
   assign rem_n_sub = rem_n_sh - {1'b0, divisor_ff};
   assign rem_d_sub = rem_d_sh - {1'b0, divisor_ff};
   assign ge_n      = (rem_n_sh >= {1'b0, divisor_ff});
   assign ge_d      = (rem_d_sh >= {1'b0, divisor_ff});

   always_comb begin
      quo_n_in = quo_n_ff;
      quo_d_in = quo_d_ff;
      rem_n_in = rem_n_ff;
      rem_d_in = rem_d_ff;
      if (cmd.div_init) begin
         quo_n_in = num_mag;
         quo_d_in = den_mag;
         rem_n_in = '0;
         rem_d_in = '0;
      end else if (cmd.div_step) begin
         quo_n_in = {quo_n_ff[RW-2:0], ge_n};
         quo_d_in = {quo_d_ff[RW-2:0], ge_d};
         rem_n_in = ge_n ? rem_n_sub[RW-1:0] : rem_n_sh[RW-1:0];
         rem_d_in = ge_d ? rem_d_sub[RW-1:0] : rem_d_sh[RW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_opcode;
         na_ff <= req_num_a;
         da_ff <= req_den_a;
         nb_ff <= req_num_b;
         db_ff <= req_den_b;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      num_ff   <= num_in;
      den_ff   <= den_in;
      gcd_a_ff <= gcd_a_in;
      gcd_b_ff <= gcd_b_in;
      shift_ff <= shift_in;
      if (cmd.div_init) begin
         divisor_ff <= gcd_a_ff << shift_ff;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
      quo_n_ff <= quo_n_in;
      quo_d_ff <= quo_d_in;
      rem_n_ff <= rem_n_in;
      rem_d_ff <= rem_d_in;
      if (cmd.out_load) begin
         res_num_ff  <= num_ff;
         res_den_ff  <= den_ff;
         zero_den_ff <= (den_ff == '0);
      end
   end

   assign status.opcode    = op_ff;
   assign status.zero_part = (num_ff == '0) || (den_ff == '0);
   assign status.gcd_done  = (gcd_a_ff == gcd_b_ff);
   assign status.div_done  = (div_cnt_ff == CW'(RW - 1));

   assign rsp_res_num  = res_num_ff;
   assign rsp_res_den  = res_den_ff;
   assign rsp_zero_den = zero_den_ff;

endmodule

`default_nettype wire

>>> rtl/core/rational_fraction_alu_core.sv
// Top level of the rational fraction ALU: controller plus datapath.
// Depends on rfalu_pkg, rfalu_ctrl and rfalu_datapath.
//
// Usage:
//   Request channel (req_*): opcode and two signed 16-bit fractions A and B.
//   A transfer happens on a rising edge with req_valid high and req_stall low.
//   Opcodes: add, subtract, multiply (straight products, not reduced), divide
//   (A times the reciprocal of B, then reduced), reduce A. Other codes pass A.
//   Response channel (rsp_*): 33-bit signed numerator and denominator plus
//   rsp_zero_den, one response per request, held while rsp_stall is high.
//
// Sequence: other codes go straight to the finish state; multiply, add and
//   subtract run their product steps. Divide and reduce add a binary GCD
//   loop (one shift or subtract per cycle over 33-bit magnitudes) and a
//   restoring divider that divides numerator and denominator in parallel,
//   then restore the sign (a zero part in reduce or divide skips both loops).
//   One request is worked on at a time; the multiplier is shared across the
//   product steps. The response register decouples the two sides, so the next
//   request is accepted while a finished response still waits to be taken.
// Reset (synchronous, active high) returns the controller to idle and drops
// any response not yet taken. A stalled receiver only holds the block in its
// finish state once a second result is ready.
`timescale 1ns / 1ps
`default_nettype none

module rational_fraction_alu_core (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       req_valid,
   output logic                                            req_stall,
   input  wire logic [rfalu_pkg::OPCODE_WIDTH-1:0]         req_opcode,
   input  wire logic signed [rfalu_pkg::OPERAND_WIDTH-1:0] req_num_a,
   input  wire logic signed [rfalu_pkg::OPERAND_WIDTH-1:0] req_den_a,
   input  wire logic signed [rfalu_pkg::OPERAND_WIDTH-1:0] req_num_b,
   input  wire logic signed [rfalu_pkg::OPERAND_WIDTH-1:0] req_den_b,
   output logic                                            rsp_valid,
   input  wire logic                                       rsp_stall,
   output logic signed [rfalu_pkg::RES_WIDTH-1:0]          rsp_res_num,
   output logic signed [rfalu_pkg::RES_WIDTH-1:0]          rsp_res_den,
   output logic                                            rsp_zero_den
);

   rfalu_pkg::cmd_type    cmd;
   rfalu_pkg::status_type status;

   // sequencing: accept, multiply steps, GCD, divide, sign restore, finish
   rfalu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   // arithmetic and the response register
   rfalu_datapath u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .status       (status),
      .req_opcode   (req_opcode),
      .req_num_a    (req_num_a),
      .req_den_a    (req_den_a),
      .req_num_b    (req_num_b),
      .req_den_b    (req_den_b),
      .rsp_res_num  (rsp_res_num),
      .rsp_res_den  (rsp_res_den),
      .rsp_zero_den (rsp_zero_den)
   );

   // a request transfer always takes the controller out of idle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted but controller did not leave idle");

   // a new response appears exactly as the controller returns to idle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("response loaded while controller still busy");

   // the flag must agree with the denominator it describes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_zero_den == (rsp_res_den == '0)))
      else $error("zero_den flag disagrees with result denominator");

endmodule

`default_nettype wire
